// ===== rtl/gtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gtbs_pkg
// Types and constants for the glyph table with binary-search lookup.
// ----------------------------------------------------------------------------
package gtbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int WIN_W       = IDX_W + 1;   // holds 0..TABLE_DEPTH
  localparam int CFG_W       = 11;
  localparam int KEY_W       = 21;

  // command codes carried on in_tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // stored glyph payload, last field (rect_x) in the lowest bits
  typedef struct packed {
    logic signed [9:0] advance_x;
    logic signed [9:0] offset_y;
    logic signed [9:0] offset_x;
    logic [9:0]        rect_height;
    logic [9:0]        rect_width;
    logic [11:0]       rect_y;
    logic [11:0]       rect_x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // input tdata layout
  typedef struct packed {
    logic [6:0]       pad;
    entry_t           entry;
    logic [KEY_W-1:0] codepoint;
    logic [9:0]       entry_index;
  } in_item_t;

  // output tdata layout
  typedef struct packed {
    logic [3:0] pad;
    entry_t     entry;
    logic [9:0] match_index;
  } out_item_t;

  localparam int IN_W  = $bits(in_item_t);
  localparam int OUT_W = $bits(out_item_t);

  // search sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_PROBE  = 4'b0100,
    S_FETCH  = 4'b1000
  } state_t;

endpackage

// ===== rtl/glyph_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// glyph_table_binary_search
// Glyph table loaded entry by entry, searched by codepoint with a binary
// search over the first glyph_count entries.
// ----------------------------------------------------------------------------
//  channel  | ports                       | contents
//  ---------+-----------------------------+----------------------------------
//  input    | in_tvalid/in_tready         | tuser: command; tdata: index, codepoint, entry
//  result   | out_tvalid/out_tready       | tuser: found; tdata: index, entry
//  config   | cfg_wen/cfg_wdata           | glyph_count
//
//  A write is stored at the edge that accepts it. A lookup runs SEARCH,
//  then PROBE once per probe (at most log2(TABLE_DEPTH)+1 = 11), then FETCH
//  on a hit or SEARCH again on a miss; an empty search window ends in a
//  miss without a probe. The key memory is read once per probe into a
//  register, the entry memory once after a hit. Items enter only while idle.
//  Reset clears the sequencer, glyph_count and the result valid; the
//  memories are not cleared. The result sits in an output register, so a
//  stalled result holds while the next item is taken in.
// ----------------------------------------------------------------------------
module glyph_table_binary_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // entry_index, codepoint, rect_x, rect_y, rect_width, rect_height,
  // offset_x, offset_y, advance_x, zero pad
  input  logic [gtbs_pkg::IN_W-1:0]  in_tdata,
  // command
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // match_index, rect_x, rect_y, rect_width, rect_height,
  // offset_x, offset_y, advance_x, zero pad
  output logic [gtbs_pkg::OUT_W-1:0] out_tdata,
  // found
  output logic                       out_tuser,
  input  logic                       cfg_wen,
  input  logic [gtbs_pkg::CFG_W-1:0] cfg_wdata
);
  import gtbs_pkg::*;

  // memories
  logic [KEY_W-1:0]   key_mem  [TABLE_DEPTH];
  entry_t             entry_mem[TABLE_DEPTH];
  logic [KEY_W-1:0]   key_rd_r;
  entry_t             entry_rd_r;

  // control and search registers
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   glyph_count_r;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [WIN_W-1:0]   lo_r, lo_nxt;
  logic [WIN_W-1:0]   hix_r, hix_nxt;     // exclusive upper bound
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic               out_tvalid_r;
  logic               out_found_r;
  out_item_t          out_data_r;

  in_item_t           in_item;
  logic               in_fire;
  logic               mem_we;
  logic               out_free;
  logic               key_rd_en;
  logic               entry_rd_en;
  logic               load_hit;
  logic               load_miss;
  logic               key_lt;
  logic               key_gt;
  logic [WIN_W-1:0]   lo_p;
  logic [WIN_W-1:0]   hix_p;
  logic [WIN_W-1:0]   win_lo;
  logic [WIN_W-1:0]   win_hix;
  logic               win_open;
  logic [WIN_W:0]     mid_sum;
  logic [IDX_W-1:0]   win_mid;
  logic [WIN_W-1:0]   count_clamped;

  assign in_item   = in_item_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mem_we    = in_fire && (in_tuser == CMD_WRITE);
  assign out_free  = !out_tvalid_r || out_tready;

  // glyph_count above the table depth searches the whole table
  assign count_clamped = (glyph_count_r > CFG_W'(TABLE_DEPTH)) ?
                         WIN_W'(TABLE_DEPTH) : WIN_W'(glyph_count_r);

  // probe compare and window update
  assign key_lt = (key_rd_r < key_r);
  assign key_gt = (key_rd_r > key_r);
  assign lo_p   = key_lt ? (WIN_W'(mid_r) + WIN_W'(1)) : lo_r;
  assign hix_p  = key_gt ? WIN_W'(mid_r) : hix_r;

  // midpoint of the window now in force: (lo + hi) / 2 with hi = hix - 1
  assign win_lo   = (state_r == S_PROBE) ? lo_p  : lo_r;
  assign win_hix  = (state_r == S_PROBE) ? hix_p : hix_r;
  assign win_open = (win_lo < win_hix);
  assign mid_sum  = {1'b0, win_lo} + {1'b0, win_hix} - (WIN_W + 1)'(1);
  assign win_mid  = mid_sum[IDX_W:1];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_count_r <= '0;
    end else if (cfg_wen) begin
      glyph_count_r <= cfg_wdata;
    end
  end

  // table memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[in_item.entry_index]   <= in_item.codepoint;
      entry_mem[in_item.entry_index] <= in_item.entry;
    end
    if (key_rd_en) begin
      key_rd_r <= key_mem[win_mid];
    end
    if (entry_rd_en) begin
      entry_rd_r <= entry_mem[mid_r];
    end
  end

  // search sequencer
  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    lo_nxt      = lo_r;
    hix_nxt     = hix_r;
    mid_nxt     = mid_r;
    key_rd_en   = 1'b0;
    entry_rd_en = 1'b0;
    load_hit    = 1'b0;
    load_miss   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser == CMD_LOOKUP)) begin
          key_nxt   = in_item.codepoint;
          lo_nxt    = '0;
          hix_nxt   = count_clamped;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // first probe, or a closed window that ends in a miss
        if (win_open) begin
          key_rd_en = 1'b1;
          mid_nxt   = win_mid;
          state_nxt = S_PROBE;
        end else if (out_free) begin
          load_miss = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PROBE: begin
        if (!key_lt && !key_gt) begin
          entry_rd_en = 1'b1;
          state_nxt   = S_FETCH;
        end else begin
          lo_nxt  = lo_p;
          hix_nxt = hix_p;
          if (win_open) begin
            key_rd_en = 1'b1;
            mid_nxt   = win_mid;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_FETCH: begin
        if (out_free) begin
          load_hit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hix_r <= hix_nxt;
    mid_r <= mid_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_hit || load_miss) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      out_found_r            <= 1'b1;
      out_data_r.pad         <= '0;
      out_data_r.entry       <= entry_rd_r;
      out_data_r.match_index <= mid_r;
    end else if (load_miss) begin
      out_found_r <= 1'b0;
      out_data_r  <= '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // assertions
  a_probe_window_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r < hix_r))
    else $error("probe with an empty search window");

  a_window_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_SEARCH) |-> (hix_r <= WIN_W'(TABLE_DEPTH)))
    else $error("search window beyond table depth");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_FETCH || $past(state_r) == S_SEARCH))
    else $error("result raised outside search end");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_found_r) |-> (out_tdata == '0))
    else $error("miss result carries nonzero fields");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (load_hit || load_miss) |-> !(out_tvalid_r && !out_tready))
    else $error("result overwrites a stalled result");

endmodule

// ===== tb/sv/glyph_table_binary_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_table_binary_search_tb
// Self-checking bench for the glyph table with binary-search lookup. Loads
// sorted and unsorted tables through the input stream, sweeps glyph_count
// from empty through beyond the table depth, and checks every lookup result
// against a scoreboard that mirrors the table and replays the search.
// Both stream sides idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module glyph_table_binary_search_tb;
  import gtbs_pkg::*;

  localparam int MAX_CP        = 1114111;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 100;

  typedef struct packed {
    logic      found;
    out_item_t item;
  } lookup_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  in_item_t         in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_wen;
  logic [CFG_W-1:0] cfg_wdata;
  out_item_t        out_fields;

  // scoreboard copy of the table and the count register
  logic [KEY_W-1:0] model_keys    [TABLE_DEPTH];
  entry_t           model_entries [TABLE_DEPTH];
  bit               slot_loaded   [TABLE_DEPTH];
  logic [CFG_W-1:0] model_count = '0;
  lookup_result_t   pending_lookups [$];

  int err_count  = 0;
  int items_sent = 0;
  int rx_hold    = 0;
  bit idle_on    = 1'b1;

  assign out_fields = out_tdata;

  glyph_table_binary_search uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // binary search over the mirrored table, zeroed result on a miss
  function automatic lookup_result_t search_glyph(logic [KEY_W-1:0] cp);
    lookup_result_t r;
    int span, lo, hi, mid;
    r    = '0;
    span = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (model_keys[mid] < cp) begin
        lo = mid + 1;
      end else if (model_keys[mid] > cp) begin
        hi = mid - 1;
      end else begin
        r.found             = 1'b1;
        r.item.match_index  = mid[IDX_W-1:0];
        r.item.entry        = model_entries[mid];
      end
    end
    return r;
  endfunction

  // number of slots loaded without a hole from slot 0
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < TABLE_DEPTH && slot_loaded[n]) n++;
    return n;
  endfunction

  function automatic entry_t make_entry(int rx, int ry, int rw, int rh,
                                        int ox, int oy, int ax);
    entry_t e;
    e.rect_x      = rx[11:0];
    e.rect_y      = ry[11:0];
    e.rect_width  = rw[9:0];
    e.rect_height = rh[9:0];
    e.offset_x    = ox[9:0];
    e.offset_y    = oy[9:0];
    e.advance_x   = ax[9:0];
    return e;
  endfunction

  function automatic entry_t rand_entry();
    return make_entry($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it             = '0;
    it.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    it.codepoint   = KEY_W'($urandom_range(0, MAX_CP));
    it.entry       = rand_entry();
    return it;
  endfunction

  // lookup key biased toward hits, neighbors of hits and random misses
  function automatic logic [KEY_W-1:0] pick_codepoint();
    int span, r;
    logic [KEY_W-1:0] k;
    span = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
    r    = $urandom_range(0, 9);
    if (span > 0 && r < 8) begin
      k = model_keys[$urandom_range(0, span - 1)];
      if (r >= 6) begin
        k = (k == KEY_W'(MAX_CP) || (k != '0 && r == 6)) ?
            k - KEY_W'(1) : k + KEY_W'(1);
      end
      return k;
    end
    return KEY_W'($urandom_range(0, MAX_CP));
  endfunction

  // one input transfer; scoreboard updated at the accepting edge
  task automatic send_item(input logic cmd, input in_item_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      model_keys[item.entry_index]    = item.codepoint;
      model_entries[item.entry_index] = item.entry;
      slot_loaded[item.entry_index]   = 1'b1;
    end else begin
      pending_lookups.push_back(search_glyph(item.codepoint));
    end
    items_sent++;
  endtask

  task automatic write_glyph(input int slot, input logic [KEY_W-1:0] cp,
                             input entry_t e);
    in_item_t it;
    it             = rand_item();
    it.entry_index = slot[IDX_W-1:0];
    it.codepoint   = cp;
    it.entry       = e;
    send_item(CMD_WRITE, it);
  endtask

  // lookup with random noise in the unused fields
  task automatic lookup_glyph(input logic [KEY_W-1:0] cp);
    in_item_t it;
    it           = rand_item();
    it.codepoint = cp;
    send_item(CMD_LOOKUP, it);
  endtask

  // drain all results, then let a trailing write settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_glyph_count(input int value);
    wait_idle();
    cfg_wdata <= value[CFG_W-1:0];
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    model_count  = value[CFG_W-1:0];
    @(posedge clk);
  endtask

  // slots 0..n-1 with strictly ascending keys, dense or spread out
  task automatic build_sorted_table(input int n);
    int i, step_max;
    logic [KEY_W-1:0] cp;
    step_max = ($urandom_range(0, 2) == 0) ? 3 : MAX_CP / n;
    cp       = KEY_W'($urandom_range(0, step_max - 1));
    for (i = 0; i < n; i++) begin
      write_glyph(i, cp, rand_entry());
      cp = cp + KEY_W'($urandom_range(1, step_max));
    end
  endtask

  // lookups on an empty table miss
  task automatic test_empty_table();
    set_glyph_count(0);
    lookup_glyph('0);
    lookup_glyph(KEY_W'(MAX_CP));
    lookup_glyph(21'h0AAAAA);
  endtask

  // field extremes, hits at both ends, misses, count of one, unsorted slot
  task automatic test_directed_table();
    logic [KEY_W-1:0] keys [8];
    int i;
    keys = '{21'h000000, 21'h000001, 21'h000041, 21'h01F600,
             21'h0AAAAA, 21'h0F5555, 21'h10FFFE, 21'h10FFFF};
    for (i = 0; i < 8; i++) begin
      if (i == 0)      write_glyph(i, keys[i], make_entry(0, 0, 0, 0, -512, -512, -512));
      else if (i == 7) write_glyph(i, keys[i], make_entry(4095, 4095, 1023, 1023,
                                                          511, 511, 511));
      else             write_glyph(i, keys[i], rand_entry());
    end
    write_glyph(TABLE_DEPTH - 1, 21'h155555, rand_entry());
    set_glyph_count(8);
    for (i = 0; i < 8; i++) lookup_glyph(keys[i]);
    lookup_glyph(21'h000040);
    lookup_glyph(21'h0F5556);
    set_glyph_count(1);
    lookup_glyph(keys[0]);
    lookup_glyph(keys[1]);
    // break the ordering: the probe path decides what is found
    write_glyph(3, 21'h000002, rand_entry());
    set_glyph_count(8);
    lookup_glyph(21'h000002);
    lookup_glyph(keys[2]);
  endtask

  // random tables and counts, lookups mixed with stray writes
  task automatic test_random_tables();
    int start, n, span;
    in_item_t it;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 40);
      build_sorted_table(n);
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, loaded_prefix()) : n;
      set_glyph_count(span);
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 9) == 0) begin
          it = rand_item();
          if ($urandom_range(0, 1) == 0) it.entry_index = IDX_W'($urandom_range(0, n - 1));
          send_item(CMD_WRITE, it);
        end else begin
          lookup_glyph(pick_codepoint());
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // whole table, deepest probes, counts at and beyond the depth
  task automatic test_full_table();
    build_sorted_table(TABLE_DEPTH);
    set_glyph_count(TABLE_DEPTH);
    lookup_glyph(model_keys[0]);
    lookup_glyph(model_keys[TABLE_DEPTH - 1]);
    repeat (40) lookup_glyph(pick_codepoint());
    set_glyph_count((1 << CFG_W) - 1);
    lookup_glyph(model_keys[TABLE_DEPTH - 1]);
    repeat (20) lookup_glyph(pick_codepoint());
    set_glyph_count(TABLE_DEPTH + 1);
    repeat (10) lookup_glyph(pick_codepoint());
  endtask

  // long receiver hold-off with the sender pushing back to back
  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_hold = 400;
    repeat (40) lookup_glyph(pick_codepoint());
    wait_idle();
    idle_on = 1'b1;
    repeat (20) lookup_glyph(pick_codepoint());
    wait_idle();
    repeat (20) lookup_glyph(pick_codepoint());
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // result receiver: random stalls per transfer, optional long hold-off
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid && rx_hold == 0) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest pending lookup
  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        $error("result transfer with no lookup pending");
        err_count++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("found", 32'(want.found), 32'(out_tuser));
        check_field("match_index", 32'(want.item.match_index),
                    32'(out_fields.match_index));
        check_field("out_rect_x", 32'(want.item.entry.rect_x),
                    32'(out_fields.entry.rect_x));
        check_field("out_rect_y", 32'(want.item.entry.rect_y),
                    32'(out_fields.entry.rect_y));
        check_field("out_rect_width", 32'(want.item.entry.rect_width),
                    32'(out_fields.entry.rect_width));
        check_field("out_rect_height", 32'(want.item.entry.rect_height),
                    32'(out_fields.entry.rect_height));
        check_field("out_offset_x", 32'(want.item.entry.offset_x),
                    32'(out_fields.entry.offset_x));
        check_field("out_offset_y", 32'(want.item.entry.offset_y),
                    32'(out_fields.entry.offset_y));
        check_field("out_advance_x", 32'(want.item.entry.advance_x),
                    32'(out_fields.entry.advance_x));
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // reset, test sequence, verdict
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_WRITE;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_table();
    test_random_tables();
    test_full_table();
    test_backpressure();
    wait_idle();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
